FILE: rtl/vic_pkg.sv
// Package with shared types and constants for the velocity integrator.
package vic_pkg;

  localparam logic [19:0] GravityQ16 = 20'd642253;
  localparam logic [14:0] HeadingOne = 15'd16384;

  typedef enum logic [2:0] {
    REG_INVERSE_MASS  = 3'd0,
    REG_BODY_MASS     = 3'd1,
    REG_FIXED_BODY    = 3'd2,
    REG_FLOATING_BODY = 3'd3,
    REG_MIN_SPEED     = 3'd4,
    REG_MAX_SPEED     = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GRAV, ST_GAIN, ST_INC, ST_SUM, ST_SQ, ST_ADD, ST_SQRT,
    ST_CLAMP, ST_CDIV, ST_HEAD, ST_HDIV, ST_OUT
  } state_t;

  // Commands from the sequencer to every lane.
  typedef struct packed {
    logic        load_inc;
    logic        add_inc;
    logic        load_sq;
    logic        start_div;
    logic        div_head;
    logic        take_clamp;
    logic        take_head;
    logic        snap_zero;
  } lane_ctl_t;

  typedef struct packed {
    logic [31:0] force_x;
    logic [31:0] force_y;
    logic [31:0] force_z;
    logic [15:0] time_step;
    logic        add_gravity;
  } in_item_t;

  typedef struct packed {
    logic [31:0] velocity_x;
    logic [31:0] velocity_y;
    logic [31:0] velocity_z;
    logic [30:0] speed;
    logic [15:0] heading_x;
    logic [15:0] heading_y;
    logic [15:0] heading_z;
  } out_item_t;

endpackage

FILE: rtl/vic_stream_if.sv
// Valid/ready channel interface carrying one item.
interface vic_stream_if #(parameter int Width = 8);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/vic_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module vic_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] div_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r[31:0], q_r[63]};
    if (cnt_r != 7'd0) begin
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = trial - {1'b0, div_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 7'd64;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = (cnt_r != 7'd0);
  assign quotient = q_r;
endmodule

FILE: rtl/vic_lane.sv
// One velocity component lane: increment, saturating sum, square and divisions.
module vic_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  vic_pkg::lane_ctl_t ctl,
  input  logic [31:0]       force_in,
  input  logic [32:0]       gain,
  input  logic [31:0]       max_speed,
  input  logic [31:0]       raw_speed,
  input  logic [30:0]       speed,
  output logic              busy,
  output logic [62:0]       square,
  output logic [31:0]       velocity,
  output logic [15:0]       heading
);
  logic [31:0] vel_r;
  logic [15:0] head_r;
  logic        fneg_r;
  logic [64:0] prod_r;
  logic [62:0] sq_r;
  logic [31:0] fmag;
  logic [31:0] vmag;
  logic [48:0] inc;
  logic signed [50:0] sum;
  logic [63:0] dvd;
  logic [31:0] dvs;
  logic [63:0] quo;
  logic [31:0] newmag;
  logic [14:0] hmag;

  assign fmag = force_in[31] ? (32'd0 - force_in) : force_in;
  assign vmag = vel_r[31] ? (32'd0 - vel_r) : vel_r;
  assign inc  = prod_r[64:16] + {48'd0, prod_r[15]};
  assign sum  = {{19{vel_r[31]}}, vel_r} +
                (fneg_r ? -$signed({2'b0, inc}) : $signed({2'b0, inc}));

  always_comb begin
    if (ctl.div_head) begin
      dvd = {18'd0, vmag, 14'd0} + {34'd0, speed[30:1]};
      dvs = {1'b0, speed};
    end else begin
      dvd = {32'd0, vmag} * {32'd0, max_speed};
      dvs = raw_speed;
    end
  end

  vic_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.start_div), .dividend(dvd),
    .divisor(dvs), .busy(busy), .quotient(quo)
  );

  assign newmag = quo[31:0];
  assign hmag = (quo > 64'(vic_pkg::HeadingOne)) ? vic_pkg::HeadingOne : quo[14:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r  <= '0;
      head_r <= '0;
    end else begin
      if (ctl.load_inc) begin
        prod_r <= {32'd0, gain} * {33'd0, fmag};
        fneg_r <= force_in[31];
      end
      if (ctl.add_inc) begin
        if (sum > 51'sd2147483647) vel_r <= 32'h7fffffff;
        else if (sum < -51'sd2147483648) vel_r <= 32'h80000000;
        else vel_r <= sum[31:0];
      end
      if (ctl.load_sq) sq_r <= {31'd0, vmag} * {31'd0, vmag};
      if (ctl.snap_zero) vel_r <= '0;
      if (ctl.take_clamp) vel_r <= vel_r[31] ? (32'd0 - newmag) : newmag;
      if (ctl.take_head) head_r <= vel_r[31] ? (16'd0 - {1'b0, hmag}) : {1'b0, hmag};
    end
  end

  assign square   = sq_r;
  assign velocity = vel_r;
  assign heading  = head_r;
endmodule

FILE: rtl/vic_sqrt.sv
// Merging stage: takes an integer square root of the summed lane squares, two bits a cycle.
module vic_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [64:0] radicand,
  output logic        busy,
  output logic [31:0] root
);
  logic [65:0] x_r;
  logic [32:0] res_r;
  logic [65:0] rem_r;
  logic [5:0]  cnt_r;
  logic [67:0] trial;
  logic [67:0] remsh;

  assign remsh = {rem_r, x_r[65:64]};
  assign trial = {33'd0, res_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= 6'd33;
      x_r   <= {1'b0, radicand};
      res_r <= '0;
      rem_r <= '0;
    end else if (cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
      x_r   <= {x_r[63:0], 2'b00};
      if (remsh >= trial) begin
        rem_r <= 66'(remsh - trial);
        res_r <= {res_r[31:0], 1'b1};
      end else begin
        rem_r <= remsh[65:0];
        res_r <= {res_r[31:0], 1'b0};
      end
    end
  end

  assign busy = (cnt_r != 6'd0);
  assign root = res_r[31:0];
endmodule

FILE: rtl/velocity_integrator_clamp.sv
// Top level: configuration registers, sequencer, three component lanes and root merge.
// A clamped speed adds the clamp division, a fixed body skips the increment and sum, and
// a speed that snaps to zero skips both divisions and goes straight to the output.
// One item at a time; the root and the lane dividers set the rate. The block is ready for
// the next item in the cycle after the result enters the output register; a result still
// held stalls the sequencer at its end.
// Reset (synchronous, rst_n low) restores the default registers and clears velocity and
// heading. No clearing pass is needed after reset.
module velocity_integrator_clamp (
  input  logic        clk,
  input  logic        rst_n,
  vic_stream_if.sink   in_ch,
  vic_stream_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  // Configuration registers.
  logic [31:0] inverse_mass_r, body_mass_r;
  logic        fixed_body_r, floating_body_r;
  logic [30:0] min_speed_r, max_speed_r;
  logic        cfg_wr;
  vic_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = vic_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inverse_mass_r  <= 32'd65536;
      body_mass_r     <= 32'd65536;
      fixed_body_r    <= 1'b0;
      floating_body_r <= 1'b0;
      min_speed_r     <= 31'd66;
      max_speed_r     <= 31'd6553600;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vic_pkg::REG_INVERSE_MASS:  inverse_mass_r  <= cfg_pwdata;
        vic_pkg::REG_BODY_MASS:     body_mass_r     <= cfg_pwdata;
        vic_pkg::REG_FIXED_BODY:    fixed_body_r    <= cfg_pwdata[0];
        vic_pkg::REG_FLOATING_BODY: floating_body_r <= cfg_pwdata[0];
        vic_pkg::REG_MIN_SPEED:     min_speed_r     <= cfg_pwdata[30:0];
        vic_pkg::REG_MAX_SPEED:     max_speed_r     <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      vic_pkg::REG_INVERSE_MASS:  cfg_prdata = inverse_mass_r;
      vic_pkg::REG_BODY_MASS:     cfg_prdata = body_mass_r;
      vic_pkg::REG_FIXED_BODY:    cfg_prdata = {31'd0, fixed_body_r};
      vic_pkg::REG_FLOATING_BODY: cfg_prdata = {31'd0, floating_body_r};
      vic_pkg::REG_MIN_SPEED:     cfg_prdata = {1'b0, min_speed_r};
      vic_pkg::REG_MAX_SPEED:     cfg_prdata = {1'b0, max_speed_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // Item capture and sequencer.
  vic_pkg::in_item_t item_r;
  vic_pkg::state_t   state_r, state_nxt;
  vic_pkg::lane_ctl_t ctl;
  logic [51:0] gprod_r;
  logic [32:0] gain_r;
  logic [30:0] speed_r;
  logic        out_valid_r;
  vic_pkg::out_item_t out_r;
  logic [2:0]  busy;
  logic [62:0] sq0, sq1, sq2;
  logic [31:0] vel0, vel1, vel2;
  logic [15:0] hd0, hd1, hd2;
  logic        sqrt_busy;
  logic [31:0] root;
  logic        snap;
  logic        do_clamp;
  logic [36:0] grav;
  logic signed [38:0] fy_sum;
  logic [31:0] fy_r;
  logic        in_fire;

  assign in_ch.ready = (state_r == vic_pkg::ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;

  // Gravity force rounded half up, then subtracted from force_y with saturation.
  // A heavy body gives a force well beyond 32 bits, so the sum is kept wide.
  assign grav   = {1'b0, gprod_r[51:16]} + {36'd0, gprod_r[15]};
  assign fy_sum = $signed({{7{item_r.force_y[31]}}, item_r.force_y}) -
                  $signed({2'b0, grav});

  // The root stays stable once the square root unit is done, so the speed tests
  // and the clamp divisor read it directly.
  assign snap     = (root < {1'b0, min_speed_r});
  assign do_clamp = (root > {1'b0, max_speed_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vic_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == vic_pkg::ST_OUT && !out_valid_r) out_valid_r <= 1'b1;
    end
    if (in_fire) item_r <= in_ch.data;
    unique case (state_r)
      vic_pkg::ST_GRAV: gprod_r <= 52'({20'd0, body_mass_r} * {32'd0, vic_pkg::GravityQ16});
      vic_pkg::ST_GAIN: begin
        gprod_r <= 52'({20'd0, inverse_mass_r} * {36'd0, item_r.time_step});
        if (item_r.add_gravity && !floating_body_r) begin
          if (fy_sum < -39'sd2147483648) fy_r <= 32'h80000000;
          else fy_r <= fy_sum[31:0];
        end else begin
          fy_r <= item_r.force_y;
        end
      end
      vic_pkg::ST_INC: gain_r <= gprod_r[48:16] + {32'd0, gprod_r[15]};
      vic_pkg::ST_CLAMP: if (!sqrt_busy) begin
        speed_r <= snap ? 31'd0 : (do_clamp ? max_speed_r : root[30:0]);
      end
      vic_pkg::ST_OUT: if (!out_valid_r) begin
        out_r <= '{velocity_x: vel0, velocity_y: vel1, velocity_z: vel2,
                   speed: speed_r, heading_x: hd0, heading_y: hd1, heading_z: hd2};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    unique case (state_r)
      vic_pkg::ST_IDLE:  if (in_fire) state_nxt = vic_pkg::ST_GRAV;
      vic_pkg::ST_GRAV:  state_nxt = vic_pkg::ST_GAIN;
      vic_pkg::ST_GAIN:  state_nxt = vic_pkg::ST_INC;
      vic_pkg::ST_INC: begin
        state_nxt = fixed_body_r ? vic_pkg::ST_SQ : vic_pkg::ST_SUM;
      end
      vic_pkg::ST_SUM: begin
        ctl.load_inc = 1'b1;
        state_nxt = vic_pkg::ST_ADD;
      end
      vic_pkg::ST_ADD: begin
        ctl.add_inc = 1'b1;
        state_nxt = vic_pkg::ST_SQ;
      end
      vic_pkg::ST_SQ: begin
        ctl.load_sq = 1'b1;
        state_nxt = vic_pkg::ST_SQRT;
      end
      vic_pkg::ST_SQRT: begin
        state_nxt = vic_pkg::ST_CLAMP;
      end
      vic_pkg::ST_CLAMP: begin
        if (sqrt_busy) begin
          state_nxt = vic_pkg::ST_CLAMP;
        end else if (snap) begin
          ctl.snap_zero = 1'b1;
          state_nxt = vic_pkg::ST_OUT;
        end else if (do_clamp) begin
          ctl.start_div = 1'b1;
          state_nxt = vic_pkg::ST_CDIV;
        end else begin
          state_nxt = vic_pkg::ST_HEAD;
        end
      end
      vic_pkg::ST_CDIV: begin
        if (busy == 3'd0) begin
          ctl.take_clamp = 1'b1;
          state_nxt = vic_pkg::ST_HEAD;
        end
      end
      vic_pkg::ST_HEAD: begin
        // A zero speed keeps the stored heading and skips the division.
        if (speed_r != 31'd0) begin
          ctl.start_div = 1'b1;
          ctl.div_head = 1'b1;
          state_nxt = vic_pkg::ST_HDIV;
        end else begin
          state_nxt = vic_pkg::ST_OUT;
        end
      end
      vic_pkg::ST_HDIV: begin
        if (busy == 3'd0) begin
          ctl.take_head = 1'b1;
          state_nxt = vic_pkg::ST_OUT;
        end
      end
      vic_pkg::ST_OUT: begin
        if (!out_valid_r) state_nxt = vic_pkg::ST_IDLE;
      end
      default: state_nxt = vic_pkg::ST_IDLE;
    endcase
  end

  vic_lane u_lane_x (.clk(clk), .rst_n(rst_n),
    .ctl(ctl), .force_in(item_r.force_x),
    .gain(gain_r), .max_speed({1'b0, max_speed_r}), .raw_speed(root),
    .speed(speed_r), .busy(busy[0]), .square(sq0), .velocity(vel0), .heading(hd0));
  vic_lane u_lane_y (.clk(clk), .rst_n(rst_n),
    .ctl(ctl), .force_in(fy_r),
    .gain(gain_r), .max_speed({1'b0, max_speed_r}), .raw_speed(root),
    .speed(speed_r), .busy(busy[1]), .square(sq1), .velocity(vel1), .heading(hd1));
  vic_lane u_lane_z (.clk(clk), .rst_n(rst_n),
    .ctl(ctl), .force_in(item_r.force_z),
    .gain(gain_r), .max_speed({1'b0, max_speed_r}), .raw_speed(root),
    .speed(speed_r), .busy(busy[2]), .square(sq2), .velocity(vel2), .heading(hd2));

  // Merge: the square root runs on the sum of the three lane squares.
  logic sqrt_go;
  assign sqrt_go = (state_r == vic_pkg::ST_SQRT);
  vic_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .start(sqrt_go),
    .radicand({2'b0, sq0} + {2'b0, sq1} + {2'b0, sq2}), .busy(sqrt_busy), .root(root));

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == vic_pkg::ST_IDLE) else $error("ready outside idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_busy |-> !in_ch.ready) else $error("accept during root");
endmodule

FILE: sim/velocity_integrator_clamp_tb.sv
// Self-checking testbench for the velocity integrator with speed clamp.
module velocity_integrator_clamp_tb;

  localparam int InW = $bits(vic_pkg::in_item_t);
  localparam int OutW = $bits(vic_pkg::out_item_t);
  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  vic_stream_if #(.Width(InW)) in_ch ();
  vic_stream_if #(.Width(OutW)) out_ch ();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  velocity_integrator_clamp dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int clamp_hits = 0;
  int snap_hits = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Scoreboard: keeps its own copy of the registers and body state, and the
  // queue of step results not yet seen at the output.
  class step_scoreboard;
    logic [31:0] inv_mass, mass;
    logic fixed, floating;
    logic [30:0] vmin, vmax;
    logic signed [31:0] vel[3];
    logic signed [15:0] head[3];
    vic_pkg::out_item_t pending[$];

    function void clear();
      inv_mass = 32'd65536;
      mass = 32'd65536;
      fixed = 1'b0;
      floating = 1'b0;
      vmin = 31'd66;
      vmax = 31'd6553600;
      for (int i = 0; i < 3; i++) begin
        vel[i] = '0;
        head[i] = '0;
      end
      pending.delete();
    endfunction

    function void write_reg(vic_pkg::reg_idx_t idx, logic [31:0] val);
      case (idx)
        vic_pkg::REG_INVERSE_MASS: inv_mass = val;
        vic_pkg::REG_BODY_MASS: mass = val;
        vic_pkg::REG_FIXED_BODY: fixed = val[0];
        vic_pkg::REG_FLOATING_BODY: floating = val[0];
        vic_pkg::REG_MIN_SPEED: vmin = val[30:0];
        vic_pkg::REG_MAX_SPEED: vmax = val[30:0];
        default: ;
      endcase
    endfunction

    static function logic signed [31:0] sat(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    static function logic [63:0] root(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Advance the body by one step and queue the result it must produce.
    function void note_step(vic_pkg::in_item_t it);
      logic signed [63:0] f[3];
      logic [63:0] g, k, m, sumsq, raw;
      logic [30:0] spd;
      vic_pkg::out_item_t res;
      f[0] = $signed(it.force_x);
      f[1] = $signed(it.force_y);
      f[2] = $signed(it.force_z);
      if (it.add_gravity && !floating) begin
        g = (64'(mass) * 64'(vic_pkg::GravityQ16) + 64'd32768) >> 16;
        f[1] = sat(f[1] - $signed(g));
      end
      if (!fixed) begin
        k = (64'(inv_mass) * 64'(it.time_step) + 64'd32768) >> 16;
        for (int i = 0; i < 3; i++) begin
          m = (k * 64'(f[i] < 0 ? -f[i] : f[i]) + 64'd32768) >> 16;
          vel[i] = sat(64'(vel[i]) + (f[i] < 0 ? -$signed(m) : $signed(m)));
        end
      end
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        m = 64'(vel[i] < 0 ? -64'(vel[i]) : 64'(vel[i]));
        sumsq += m * m;
      end
      raw = root(sumsq);
      if (raw < 64'(vmin)) begin
        for (int i = 0; i < 3; i++) vel[i] = '0;
        spd = '0;
        snap_hits++;
      end else begin
        if (raw > 64'(vmax)) begin
          for (int i = 0; i < 3; i++) begin
            m = (vel[i] < 0 ? -64'(vel[i]) : 64'(vel[i])) * 64'(vmax) / raw;
            vel[i] = vel[i] < 0 ? -$signed(m[31:0]) : $signed(m[31:0]);
          end
          spd = vmax;
          clamp_hits++;
        end else begin
          spd = raw[30:0];
        end
        // With a zero final speed the stored heading simply stays.
        if (spd != 0) begin
          for (int i = 0; i < 3; i++) begin
            m = ((vel[i] < 0 ? -64'(vel[i]) : 64'(vel[i])) * 64'(vic_pkg::HeadingOne)
                 + 64'(spd / 2)) / 64'(spd);
            if (m > 64'(vic_pkg::HeadingOne)) m = 64'(vic_pkg::HeadingOne);
            head[i] = vel[i] < 0 ? -$signed(m[15:0]) : $signed(m[15:0]);
          end
        end
      end
      res.velocity_x = vel[0];
      res.velocity_y = vel[1];
      res.velocity_z = vel[2];
      res.speed = spd;
      res.heading_x = head[0];
      res.heading_y = head[1];
      res.heading_z = head[2];
      pending.push_back(res);
    endfunction

    task check_result(vic_pkg::out_item_t got);
      vic_pkg::out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected item", got.velocity_x, '0);
        return;
      end
      want = pending.pop_front();
      if (got.velocity_x !== want.velocity_x)
        report("velocity_x", got.velocity_x, want.velocity_x);
      if (got.velocity_y !== want.velocity_y)
        report("velocity_y", got.velocity_y, want.velocity_y);
      if (got.velocity_z !== want.velocity_z)
        report("velocity_z", got.velocity_z, want.velocity_z);
      if (got.speed !== want.speed) report("speed", 32'(got.speed), 32'(want.speed));
      if (got.heading_x !== want.heading_x)
        report("heading_x", 32'(got.heading_x), 32'(want.heading_x));
      if (got.heading_y !== want.heading_y)
        report("heading_y", 32'(got.heading_y), 32'(want.heading_y));
      if (got.heading_z !== want.heading_z)
        report("heading_z", 32'(got.heading_z), 32'(want.heading_z));
    endtask
  endclass

  step_scoreboard body_sb = new();

  // Watchdog and cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Input acceptance is recorded here so the expectation exists before the result.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      body_sb.note_step(vic_pkg::in_item_t'(in_ch.data));
    if (rst_n && out_ch.valid && out_ch.ready)
      body_sb.check_result(vic_pkg::out_item_t'(out_ch.data));
  end

  // Receiver: random stalls, plus a long hold-off window on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic cfg_write(input vic_pkg::reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 5'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    body_sb.write_reg(idx, val);
  endtask

  // Offer one item and hold it until the block takes it.
  task automatic send_step(input vic_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk);
      in_ch.valid <= 1'b0;
    end
    @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    in_ch.valid <= 1'b0;
  endtask

  // Waits until every queued result has come back, then a settling pause.
  task automatic drain();
    while (body_sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_force();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(2000) - 1000;
      3: return $signed($urandom_range(20'hfffff)) - 32'sd524288;
      default: return $urandom;
    endcase
  endfunction

  function automatic vic_pkg::in_item_t rand_step();
    vic_pkg::in_item_t it;
    it.force_x = rand_force();
    it.force_y = rand_force();
    it.force_z = rand_force();
    it.time_step = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
    it.add_gravity = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic vic_pkg::in_item_t mk(input logic [31:0] fx, fy, fz,
                                           input logic [15:0] dt, input logic grav);
    vic_pkg::in_item_t it;
    it.force_x = fx;
    it.force_y = fy;
    it.force_z = fz;
    it.time_step = dt;
    it.add_gravity = grav;
    return it;
  endfunction

  // One setting of the registers, chosen at random within a phase.
  task automatic random_config();
    cfg_write(vic_pkg::REG_INVERSE_MASS,
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000));
    cfg_write(vic_pkg::REG_BODY_MASS,
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000));
    cfg_write(vic_pkg::REG_FIXED_BODY, 32'($urandom_range(7) == 0));
    cfg_write(vic_pkg::REG_FLOATING_BODY, $urandom_range(1));
    cfg_write(vic_pkg::REG_MIN_SPEED,
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(5000));
    cfg_write(vic_pkg::REG_MAX_SPEED,
              ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000000));
  endtask

  initial begin
    body_sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: force extremes with the reset registers, then the
    // special cases: gravity on and off, fixed body, snap to zero, clamp,
    // and a zero ceiling that leaves the heading as stored.
    send_step(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'hffff, 1'b1));
    send_step(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff, 1'b0));
    send_step(mk(32'd0, 32'd0, 32'd0, 16'd0, 1'b0));
    send_step(mk(32'h00010000, 32'd0, 32'd0, 16'd1000, 1'b1));
    send_step(mk(32'd1, 32'hffffffff, 32'd1, 16'd1, 1'b0));
    drain();
    cfg_write(vic_pkg::REG_FLOATING_BODY, 32'd1);
    send_step(mk(32'd0, 32'd0, 32'h00020000, 16'd30000, 1'b1));
    drain();
    cfg_write(vic_pkg::REG_FIXED_BODY, 32'd1);
    send_step(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff, 1'b1));
    drain();
    cfg_write(vic_pkg::REG_MAX_SPEED, 32'd0);
    send_step(mk(32'd5, 32'd5, 32'd5, 16'd5, 1'b0));
    drain();
    cfg_write(vic_pkg::REG_MAX_SPEED, 32'h7fffffff);
    cfg_write(vic_pkg::REG_MIN_SPEED, 32'h7fffffff);
    send_step(mk(32'd5, 32'd5, 32'd5, 16'd5, 1'b0));
    drain();
    cfg_write(vic_pkg::REG_MIN_SPEED, 32'd0);
    send_step(mk(32'd0, 32'd0, 32'd0, 16'd0, 1'b0));
    drain();
    cfg_write(vic_pkg::REG_FIXED_BODY, 32'd0);
    cfg_write(vic_pkg::REG_FLOATING_BODY, 32'd0);
    cfg_write(vic_pkg::REG_INVERSE_MASS, 32'hffffffff);
    cfg_write(vic_pkg::REG_BODY_MASS, 32'hffffffff);
    send_step(mk(32'h00001000, 32'd0, 32'hfffff000, 16'hffff, 1'b1));
    send_step(mk(32'h80000000, 32'h80000000, 32'h80000000, 16'hffff, 1'b1));
    drain();
    cfg_write(vic_pkg::REG_INVERSE_MASS, 32'd0);
    cfg_write(vic_pkg::REG_BODY_MASS, 32'd0);
    send_step(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff, 1'b1));
    drain();

    // Random part in three idle regimes, several register settings each.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 52 : 0;
      recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 20 : 0;
      for (int set = 0; set < 5; set++) begin
        random_config();
        // Long receiver hold-off so the block fills and stalls its input.
        if (phase == 2 && set == 0) hold_cycles = 1500;
        for (int n = 0; n < 82; n++) send_step(rand_step());
        drain();
      end
    end

    $display("covered directed extremes and %0d clamped, %0d snapped steps", clamp_hits,
             snap_hits);
    $display("ran three idle regimes with register settings across their full ranges");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
